@@ rtl/core/kmc_pkg.sv @@
// kmc_pkg: shared types and constants for the 1-d k-means cluster block
// no dependencies; imported by kmc_cell, kmc_div and kmeans_1d_cluster
package kmc_pkg;

  localparam int VAL_W            = 24;
  localparam int DIST_W           = 25;
  localparam int MAX_POINTS_DEF   = 4096;
  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int ITER_W           = 16;
  localparam int NC_W             = 5;
  localparam int CFG_AW           = 1;
  localparam int CFG_DW           = 16;
  localparam int IN_DATA_W        = 32;
  localparam int IN_USER_W        = 2;
  localparam int OUT_DATA_W       = 64;
  localparam int OUT_IDX_W        = 4;
  localparam int OUT_CNT_W        = 13;
  localparam int SLOT_W           = 4;

  // func codes carried on tuser
  localparam logic [IN_USER_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [IN_USER_W-1:0] FUNC_SET    = 2'd1;
  localparam logic [IN_USER_W-1:0] FUNC_RUN    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_NUM_CLUSTERS = 1'b0;
  localparam logic [CFG_AW-1:0] REG_MAX_ITER     = 1'b1;

  // point token handed from cell to cell
  typedef struct packed {
    logic                    vld;
    logic signed [VAL_W-1:0] pt;
    logic [DIST_W-1:0]       dmin;  // smallest distance seen so far
    logic [DIST_W-1:0]       dcur;  // distance to the currently assigned centroid
  } token_t;

endpackage

@@ rtl/core/kmc_ram.sv @@
// kmc_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module kmc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                        wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                        rdata
);
  logic [W-1:0] mem [0:D-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/kmc_cell.sv @@
// kmc_cell: one cluster cell; holds centroid, sum and count, compares the
// passing point against its centroid; depends on kmc_pkg
module kmc_cell #(
  parameter int CI   = 0,
  parameter int IW   = 4,
  parameter int AW   = 12,
  parameter int CNTW = 13,
  parameter int SW   = 37
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [IW:0]                   k,
  input  kmc_pkg::token_t               tok_i,
  input  logic [IW-1:0]                 a_i,
  input  logic [IW-1:0]                 best_i,
  input  logic [AW-1:0]                 addr_i,
  output kmc_pkg::token_t               tok_o,
  output logic [IW-1:0]                 a_o,
  output logic [IW-1:0]                 best_o,
  output logic [AW-1:0]                 addr_o,
  input  logic                          set_en,
  input  logic [IW-1:0]                 set_idx,
  input  logic signed [kmc_pkg::VAL_W-1:0] set_val,
  input  logic                          clr,
  input  logic                          acc_vld,
  input  logic [IW-1:0]                 acc_idx,
  input  logic signed [kmc_pkg::VAL_W-1:0] acc_pt,
  output logic signed [kmc_pkg::VAL_W-1:0] cent_o,
  output logic signed [SW-1:0]          sum_o,
  output logic [CNTW-1:0]               cnt_o
);
  import kmc_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(CI);

  logic signed [VAL_W-1:0] cent_r;
  logic signed [SW-1:0]    sum_r;
  logic [CNTW-1:0]         cnt_r;
  token_t                  tok_r;
  logic [IW-1:0]           a_r, best_r;
  logic [AW-1:0]           addr_r;
  logic                    en;
  logic signed [DIST_W-1:0] diff;
  logic [DIST_W-1:0]       abs_d;
  token_t                  tok_nxt;
  logic [IW-1:0]           best_nxt;

  assign en = ((IW+1)'(CI) < k);

  // distance to this centroid
  always_comb begin
    diff  = DIST_W'(tok_i.pt) - DIST_W'(cent_r);
    abs_d = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
  end

  // compare and forward
  always_comb begin
    tok_nxt  = tok_i;
    best_nxt = best_i;
    if (en) begin
      if (abs_d < tok_i.dmin) begin
        tok_nxt.dmin = abs_d;
        best_nxt     = MY_IDX;
      end
      if (a_i == MY_IDX) begin
        tok_nxt.dcur = abs_d;
      end
    end
  end

  // chain stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.pt   <= tok_nxt.pt;
    tok_r.dmin <= tok_nxt.dmin;
    tok_r.dcur <= tok_nxt.dcur;
    a_r        <= a_i;
    best_r     <= best_nxt;
    addr_r     <= addr_i;
  end

  // centroid, sum and count of this cluster
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cent_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else begin
      if (set_en && set_idx == MY_IDX) begin
        cent_r <= set_val;
      end
      if (clr) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else if (acc_vld && acc_idx == MY_IDX) begin
        sum_r <= sum_r + SW'(acc_pt);
        cnt_r <= cnt_r + CNTW'(1);
      end
    end
  end

  assign tok_o  = tok_r;
  assign a_o    = a_r;
  assign best_o = best_r;
  assign addr_o = addr_r;
  assign cent_o = cent_r;
  assign sum_o  = sum_r;
  assign cnt_o  = cnt_r;
endmodule

@@ rtl/core/kmc_div.sv @@
// kmc_div: restoring divider, one quotient bit per cycle, truncates toward zero
// depends on kmc_pkg
module kmc_div #(
  parameter int NW = 37,
  parameter int DW = 13
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [NW-1:0]             num,
  input  logic [DW-1:0]                    den,
  output logic                             done,
  output logic signed [kmc_pkg::VAL_W-1:0] quo
);
  import kmc_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic          busy_r, done_r, neg_r;
  logic [CW-1:0] cnt_r;
  logic [DW:0]   rem_r;
  logic [NW-1:0] q_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_r[DW-1:0], q_r[NW-1]};
  assign ge    = (trial >= {1'b0, den_r});

  // one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      q_r   <= num[NW-1] ? NW'(-num) : NW'(num);
      neg_r <= num[NW-1];
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? (trial - {1'b0, den_r}) : trial;
      q_r   <= {q_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? VAL_W'(-q_r[VAL_W-1:0]) : VAL_W'(q_r[VAL_W-1:0]);
endmodule

@@ rtl/core/kmeans_1d_cluster.sv @@
// kmeans_1d_cluster: top level of the 1-d lloyd k-means block
// depends on kmc_pkg, kmc_ram, kmc_cell, kmc_div
//
// Append beats put points into a point ram, one per beat, and set-centroid
// beats load one centroid each. A run beat clusters the stored points: each
// pass streams the n points from ram, one per cycle, through a row of
// MAX_CLUSTERS cells, each cell comparing the point to its centroid and
// accumulating the sum and count of its members. After the stream the
// pipeline drains, each of the k clusters that has members gets a new
// centroid from the divider (one quotient bit per cycle over the 37-bit
// sum), empty ones keep theirs, and the loop decision follows. Then k result
// beats follow, one per cycle while out_tready is high, and the block then
// returns to idle. New input is taken only when the block is idle again.
// No clearing pass is needed after reset.
module kmeans_1d_cluster #(
  parameter int MAX_POINTS   = kmc_pkg::MAX_POINTS_DEF,
  parameter int MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [kmc_pkg::IN_DATA_W-1:0]    in_tdata,   // value[23:0], slot[27:24]
  input  logic [kmc_pkg::IN_USER_W-1:0]    in_tuser,   // func[1:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [kmc_pkg::OUT_DATA_W-1:0]   out_tdata,  // cluster_index[3:0],
                                                       // centroid[27:4],
                                                       // member_count[40:28],
                                                       // passes[56:41],
                                                       // hit_limit[57]
  output logic                             out_tlast,  // last
  input  logic                             cfg_we,
  input  logic [kmc_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [kmc_pkg::CFG_DW-1:0]       cfg_wdata
);
  import kmc_pkg::*;

  localparam int MC   = MAX_CLUSTERS;
  localparam int IW   = (MC > 1) ? $clog2(MC) : 1;
  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PCW  = $clog2(MAX_POINTS + 1);
  localparam int SW   = VAL_W + PCW;
  localparam int DRW  = $clog2(MC + 4);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PASS  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]        state_r;
  logic [NC_W-1:0]   num_clusters_r;
  logic [ITER_W-1:0] max_iter_r;
  logic [PCW-1:0]    point_cnt_r, rd_i_r;
  logic [ITER_W-1:0] pass_r;
  logic              moved_r, first_r, dv_run_r, clr_r;
  logic [DRW-1:0]    drain_r;
  logic [IW:0]       dv_idx_r, em_idx_r;
  logic              inj_vld_r;
  logic [AW-1:0]     inj_addr_r;
  logic              acc_vld_r;
  logic [IW-1:0]     acc_idx_r;
  logic signed [VAL_W-1:0] acc_pt_r;
  logic              out_vld_r, out_last_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [IW:0]       k_eff;
  logic [ITER_W-1:0] cap;
  logic [7:0]        nc8;
  logic              in_acc;
  logic signed [VAL_W-1:0] in_value;
  logic [SLOT_W-1:0] in_slot;

  // effective cluster count and iteration cap
  always_comb begin
    nc8 = 8'(num_clusters_r);
    if (nc8 == 8'd0) begin
      k_eff = (IW+1)'(1);
    end else if (nc8 > 8'(MC)) begin
      k_eff = (IW+1)'(MC);
    end else begin
      k_eff = (IW+1)'(nc8);
    end
    cap = (max_iter_r == '0) ? ITER_W'(1) : max_iter_r;
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_value  = in_tdata[VAL_W-1:0];
  assign in_slot   = in_tdata[VAL_W +: SLOT_W];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_clusters_r <= NC_W'(1);
      max_iter_r     <= ITER_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_NUM_CLUSTERS: num_clusters_r <= cfg_wdata[NC_W-1:0];
        REG_MAX_ITER:     max_iter_r     <= cfg_wdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // point and assignment rams
  logic              pt_we;
  logic signed [VAL_W-1:0] pt_rdata;
  logic              asg_we;
  logic [AW-1:0]     asg_waddr;
  logic [IW-1:0]     asg_wdata, asg_rdata;

  assign pt_we = in_acc && (in_tuser == FUNC_APPEND) && (point_cnt_r < PCW'(MAX_POINTS));

  kmc_ram #(.W(VAL_W), .D(MAX_POINTS)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (point_cnt_r[AW-1:0]),
    .wdata (in_value),
    .raddr (rd_i_r[AW-1:0]),
    .rdata (pt_rdata)
  );

  kmc_ram #(.W(IW), .D(MAX_POINTS)) u_asg_ram (
    .clk   (clk),
    .we    (asg_we),
    .waddr (asg_waddr),
    .wdata (asg_wdata),
    .raddr (rd_i_r[AW-1:0]),
    .rdata (asg_rdata)
  );

  // cell row
  token_t            tok  [0:MC];
  logic [IW-1:0]     a_s  [0:MC];
  logic [IW-1:0]     b_s  [0:MC];
  logic [AW-1:0]     ad_s [0:MC];
  logic signed [VAL_W-1:0] cent_c [0:MC-1];
  logic signed [SW-1:0]    sum_c  [0:MC-1];
  logic [PCW-1:0]          cnt_c  [0:MC-1];
  logic              set_en;
  logic [IW-1:0]     set_idx;
  logic signed [VAL_W-1:0] set_val;

  always_comb begin
    tok[0].vld  = inj_vld_r;
    tok[0].pt   = pt_rdata;
    tok[0].dmin = '1;
    tok[0].dcur = '1;
    a_s[0]      = first_r ? '0 : asg_rdata;
    b_s[0]      = '0;
    ad_s[0]     = inj_addr_r;
  end

  for (genvar g = 0; g < MC; g++) begin : g_cell
    kmc_cell #(.CI(g), .IW(IW), .AW(AW), .CNTW(PCW), .SW(SW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .k       (k_eff),
      .tok_i   (tok[g]),
      .a_i     (a_s[g]),
      .best_i  (b_s[g]),
      .addr_i  (ad_s[g]),
      .tok_o   (tok[g+1]),
      .a_o     (a_s[g+1]),
      .best_o  (b_s[g+1]),
      .addr_o  (ad_s[g+1]),
      .set_en  (set_en),
      .set_idx (set_idx),
      .set_val (set_val),
      .clr     (clr_r),
      .acc_vld (acc_vld_r),
      .acc_idx (acc_idx_r),
      .acc_pt  (acc_pt_r),
      .cent_o  (cent_c[g]),
      .sum_o   (sum_c[g]),
      .cnt_o   (cnt_c[g])
    );
  end

  // end of row: final assignment and move detection
  logic          fin_moved;
  logic [IW-1:0] fin_a;
  assign fin_moved = tok[MC].vld && (tok[MC].dmin < tok[MC].dcur);
  assign fin_a     = (tok[MC].dmin < tok[MC].dcur) ? b_s[MC] : a_s[MC];
  assign asg_we    = tok[MC].vld;
  assign asg_waddr = ad_s[MC];
  assign asg_wdata = fin_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= 1'b0;
    end else begin
      acc_vld_r <= tok[MC].vld;
    end
    acc_idx_r <= fin_a;
    acc_pt_r  <= tok[MC].pt;
  end

  // divider for the new centroids
  logic                    dv_start, dv_done;
  logic signed [VAL_W-1:0] dv_quo;
  logic [IW-1:0]           dv_sel, em_sel;

  assign dv_sel = dv_idx_r[IW-1:0];
  assign em_sel = em_idx_r[IW-1:0];
  assign dv_start = (state_r == S_DIV) && !dv_run_r && (dv_idx_r != k_eff)
                    && (cnt_c[dv_sel] != '0);

  kmc_div #(.NW(SW), .DW(PCW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (sum_c[dv_sel]),
    .den   (cnt_c[dv_sel]),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // centroid writes: from input beats or from the divider
  always_comb begin
    if (state_r == S_DIV) begin
      set_en  = dv_run_r && dv_done;
      set_idx = dv_sel;
      set_val = dv_quo;
    end else begin
      set_en  = in_acc && (in_tuser == FUNC_SET) && (8'(in_slot) < 8'(MC));
      set_idx = IW'(in_slot);
      set_val = in_value;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      point_cnt_r <= '0;
      inj_vld_r   <= 1'b0;
      clr_r       <= 1'b0;
      out_vld_r   <= 1'b0;
      dv_run_r    <= 1'b0;
      moved_r     <= 1'b0;
      first_r     <= 1'b0;
      pass_r      <= '0;
    end else begin
      inj_vld_r <= 1'b0;
      clr_r     <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (pt_we) begin
            point_cnt_r <= point_cnt_r + PCW'(1);
          end
          if (in_acc && in_tuser == FUNC_RUN) begin
            state_r <= S_PASS;
            first_r <= 1'b1;
            pass_r  <= '0;
            moved_r <= 1'b0;
            rd_i_r  <= '0;
            clr_r   <= 1'b1;
          end
        end
        S_PASS: begin
          if (rd_i_r < point_cnt_r) begin
            inj_vld_r  <= 1'b1;
            inj_addr_r <= rd_i_r[AW-1:0];
            rd_i_r     <= rd_i_r + PCW'(1);
          end else begin
            state_r <= S_DRAIN;
            drain_r <= '0;
          end
        end
        S_DRAIN: begin
          if (drain_r == DRW'(MC + 3)) begin
            state_r  <= S_DIV;
            dv_idx_r <= '0;
            dv_run_r <= 1'b0;
            pass_r   <= pass_r + ITER_W'(1);
            first_r  <= 1'b0;
          end else begin
            drain_r <= drain_r + DRW'(1);
          end
        end
        S_DIV: begin
          if (!dv_run_r) begin
            if (dv_idx_r == k_eff) begin
              if (moved_r && pass_r < cap) begin
                state_r <= S_PASS;
                moved_r <= 1'b0;
                rd_i_r  <= '0;
                clr_r   <= 1'b1;
              end else begin
                state_r  <= S_EMIT;
                em_idx_r <= '0;
              end
            end else if (dv_start) begin
              dv_run_r <= 1'b1;
            end else begin
              dv_idx_r <= dv_idx_r + (IW+1)'(1);
            end
          end else if (dv_done) begin
            dv_run_r <= 1'b0;
            dv_idx_r <= dv_idx_r + (IW+1)'(1);
          end
        end
        S_EMIT: begin
          if (!out_vld_r || out_tready) begin
            if (em_idx_r != k_eff) begin
              out_vld_r  <= 1'b1;
              out_last_r <= (em_idx_r + (IW+1)'(1) == k_eff);
              out_data_r <= {6'd0, moved_r, pass_r, OUT_CNT_W'(cnt_c[em_sel]),
                             cent_c[em_sel], OUT_IDX_W'(em_idx_r)};
              em_idx_r   <= em_idx_r + (IW+1)'(1);
            end else begin
              out_vld_r   <= 1'b0;
              point_cnt_r <= '0;
              state_r     <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (fin_moved) begin
        moved_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // checks
  a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> state_r == S_EMIT) else $error("result beat outside emit");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("input taken while results pending");
  a_pass_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> pass_r <= cap && pass_r != '0) else $error("pass count out of range");
  a_pt_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    point_cnt_r <= PCW'(MAX_POINTS)) else $error("point count overflow");
  a_chain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> !tok[MC].vld && !acc_vld_r) else $error("chain busy in divide");
endmodule
